// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the ring RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable and a fixed message.
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion with the default message.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	`ASSERT_CLK_MSG(lbl, clk, rst_n, prop, "ring assertion failed")

`endif

// ===== hw/rtl/dor_pkg.sv =====
// Package for the drop-oldest event ring: sizes, codes and the command type.
// Depends on nothing; used by every module of the block.
`default_nettype none
package dor_pkg;
	localparam int RING_DEPTH     = 1024;
	localparam int EVENT_BITS     = 64;
	localparam int READ_BURST_MAX = 16;
	localparam int RESULT_CAP     = 16;
	localparam int BURST_LIMIT    = (READ_BURST_MAX < RESULT_CAP) ? READ_BURST_MAX : RESULT_CAP;
	localparam int ADDR_W         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W          = $clog2(BURST_LIMIT + 1);
	localparam int HEAD_W         = 32;
	localparam int WORD_W         = 64;
	localparam int KIND_W         = 2;
	localparam int REQ_W          = 5;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TAKE = 2'd2;

	typedef enum logic [2:0] {
		ST_EVENT   = 3'd0,
		ST_PUSHED  = 3'd1,
		ST_DROPPED = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_INVALID = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_READ,
		CMD_TAKE,
		CMD_INVALID
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t               op;
		logic [EVENT_BITS-1:0] data;
		logic [CNT_W-1:0]      count;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} back_state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dor_front.sv =====
// Front end of the ring: classifies each accepted beat into a command and
// queues it for the back end. Depends on dor_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module dor_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [dor_pkg::KIND_W-1:0]  kind,
	input  wire logic [dor_pkg::WORD_W-1:0]  event_word,
	input  wire logic [dor_pkg::REQ_W-1:0]   max_events,
	output logic                             busy,
	output logic                             cmd_valid,
	output dor_pkg::cmd_t                    cmd,
	input  wire logic                        cmd_pop
);
	import dor_pkg::*;

	cmd_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cls;
	logic              accept;

	always_comb begin
		cls.data  = event_word[EVENT_BITS-1:0];
		cls.count = (max_events > REQ_W'(BURST_LIMIT)) ? CNT_W'(BURST_LIMIT)
		                                                : CNT_W'(max_events);
		priority if (kind == KIND_PUSH) begin
			cls.op = CMD_PUSH;
		end else if (kind == KIND_READ) begin
			cls.op = (max_events == '0) ? CMD_INVALID : CMD_READ;
		end else if (kind == KIND_TAKE) begin
			cls.op = CMD_TAKE;
		end else begin
			cls.op = CMD_INVALID;
		end
	end

	assign busy      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign accept    = start && !busy;
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({accept, cmd_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= QCNT_W'(QUEUE_DEPTH))
	`ASSERT_CLK(a_pop_nonempty, clk, arst_n, cmd_pop |-> count_q != '0)
	`ASSERT_CLK(a_accept_fills, clk, arst_n, accept |=> count_q != '0)
endmodule
`default_nettype wire

// ===== hw/rtl/dor_back.sv =====
// Back end of the ring: owns the slot memory and the heads, carries out
// queued commands and drives the result beats. Depends on dor_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module dor_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	input  wire dor_pkg::cmd_t               cmd,
	output logic                             cmd_pop,
	output logic                             done,
	output logic [2:0]                       status,
	output logic [dor_pkg::WORD_W-1:0]       event_out,
	output logic                             last,
	output logic [dor_pkg::HEAD_W-1:0]       drop_total
);
	import dor_pkg::*;

	logic [EVENT_BITS-1:0] slot_mem [RING_DEPTH];
	logic [EVENT_BITS-1:0] rd_data_q;

	back_state_t       state_q, state_d;
	logic [HEAD_W-1:0] prod_q, prod_d;
	logic [HEAD_W-1:0] copro_q, copro_d;
	logic [HEAD_W-1:0] user_q, user_d;
	logic [HEAD_W-1:0] drop_q, drop_d;
	logic [CNT_W-1:0]  remain_q, remain_d;

	logic              iss_valid;
	status_t           iss_status;
	logic              iss_last;
	logic              iss_mem;
	logic              burst_start;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;

	logic              valid_s2;
	status_t           status_s2;
	logic              last_s2;
	logic              mem_s2;
	logic [HEAD_W-1:0] drop_s2;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (burst_start && !iss_last) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (iss_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop     = (state_q == BK_IDLE) && cmd_valid;
		iss_valid   = 1'b0;
		iss_status  = ST_INVALID;
		iss_last    = 1'b1;
		iss_mem     = 1'b0;
		burst_start = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = user_q[ADDR_W-1:0];
		wr_en       = 1'b0;
		prod_d      = prod_q;
		copro_d     = copro_q;
		user_d      = user_q;
		drop_d      = drop_q;
		remain_d    = remain_q;
		if (state_q == BK_READ) begin
			iss_valid  = 1'b1;
			iss_status = ST_EVENT;
			iss_mem    = 1'b1;
			rd_en      = 1'b1;
			user_d     = user_q + 1'b1;
			iss_last   = (remain_q == CNT_W'(1)) || (user_d == prod_q);
			remain_d   = remain_q - 1'b1;
		end else if (cmd_valid) begin
			iss_valid = 1'b1;
			unique case (cmd.op)
				CMD_PUSH: begin
					wr_en      = 1'b1;
					prod_d     = prod_q + 1'b1;
					iss_status = ST_PUSHED;
					if ((prod_d - copro_q) > HEAD_W'(RING_DEPTH)) begin
						drop_d     = drop_q + 1'b1;
						copro_d    = copro_q + 1'b1;
						iss_status = ST_DROPPED;
					end
				end
				CMD_TAKE: begin
					if (copro_q == prod_q) begin
						iss_status = ST_EMPTY;
					end else begin
						iss_status = ST_EVENT;
						iss_mem    = 1'b1;
						rd_en      = 1'b1;
						rd_addr    = copro_q[ADDR_W-1:0];
						copro_d    = copro_q + 1'b1;
					end
				end
				CMD_READ: begin
					if (user_q == prod_q) begin
						iss_status = ST_EMPTY;
					end else begin
						iss_status  = ST_EVENT;
						iss_mem     = 1'b1;
						rd_en       = 1'b1;
						burst_start = 1'b1;
						user_d      = user_q + 1'b1;
						iss_last    = (cmd.count == CNT_W'(1)) || (user_d == prod_q);
						remain_d    = cmd.count - 1'b1;
					end
				end
				default: begin
					iss_status = ST_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[prod_q[ADDR_W-1:0]] <= cmd.data;
		end
		if (rd_en) begin
			rd_data_q <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		status_s2 <= iss_status;
		last_s2   <= iss_last;
		mem_s2    <= iss_mem;
		drop_s2   <= drop_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			prod_q   <= '0;
			copro_q  <= '0;
			user_q   <= '0;
			drop_q   <= '0;
			remain_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			state_q  <= state_d;
			prod_q   <= prod_d;
			copro_q  <= copro_d;
			user_q   <= user_d;
			drop_q   <= drop_d;
			remain_q <= remain_d;
			valid_s2 <= iss_valid;
		end
	end

	assign done       = valid_s2;
	assign status     = status_s2;
	assign event_out  = mem_s2 ? WORD_W'(rd_data_q) : '0;
	assign last       = last_s2;
	assign drop_total = drop_s2;

	`ASSERT_CLK(a_copro_lag, clk, arst_n, (prod_q - copro_q) <= HEAD_W'(RING_DEPTH))
	`ASSERT_CLK(a_burst_not_empty, clk, arst_n, (state_q == BK_READ) |-> (user_q != prod_q))
	`ASSERT_CLK(a_burst_remain, clk, arst_n, (state_q == BK_READ) |-> (remain_q != '0))
	`ASSERT_CLK(a_mem_is_event, clk, arst_n, (valid_s2 && mem_s2) |-> (status_s2 == ST_EVENT))
endmodule
`default_nettype wire

// ===== hw/rtl/drop_oldest_event_ring.sv =====
// Top level of the drop-oldest event ring: front classifier and command
// queue feeding the execution back end. Depends on dor_pkg, dor_front, dor_back.
//
// A beat is taken when start is high and busy is low; busy rises only while
// the two-entry command queue is full. Each command runs in the back end at
// one memory access per cycle: a push, a take, an empty or invalid request
// gives a single result, and a user read gives one result per event read,
// one result per cycle. Results appear on the result ports for one cycle,
// marked by done, always in order. The first result of a beat passes the
// command queue and the result stage registers before it reaches the ports;
// the receiver cannot stall results. The slot memory needs no clearing
// after reset.
`default_nettype none
module drop_oldest_event_ring (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [dor_pkg::KIND_W-1:0]  kind,
	input  wire logic [dor_pkg::WORD_W-1:0]  event_word,
	input  wire logic [dor_pkg::REQ_W-1:0]   max_events,
	output logic                             done,
	output logic [2:0]                       status,
	output logic [dor_pkg::WORD_W-1:0]       event_out,
	output logic                             last,
	output logic [dor_pkg::HEAD_W-1:0]       drop_total
);
	import dor_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	dor_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.kind       (kind),
		.event_word (event_word),
		.max_events (max_events),
		.busy       (busy),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	dor_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.done       (done),
		.status     (status),
		.event_out  (event_out),
		.last       (last),
		.drop_total (drop_total)
	);
endmodule
`default_nettype wire
